// ===== sv/lkv_pkg.sv =====
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared sizes, types and codes of the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

	localparam int CAPACITY   = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;
	localparam int CFG_BITS   = 5;

	localparam int IDX_BITS  = $clog2(CAPACITY);
	localparam int RANK_BITS = $clog2(CAPACITY);
	localparam int CNT_BITS  = $clog2(CAPACITY + 1);
	// Width in which the occupancy and the capacity setting are compared.
	localparam int CMP_BITS  = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;

	typedef logic [KEY_BITS-1:0]   key_t;
	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [IDX_BITS-1:0]   idx_t;
	typedef logic [RANK_BITS-1:0]  rank_t;
	typedef logic [CNT_BITS-1:0]   cnt_t;
	typedef logic [CFG_BITS-1:0]   cfg_t;

	typedef enum logic {
		CMD_GET = 1'b0,
		CMD_SET = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t   cmd;
		key_t   key;
		value_t value;
	} req_t;

	typedef struct packed {
		logic   hit;
		value_t read_value;
		logic   evicted;
		key_t   evicted_key;
	} rsp_t;

	// Outcome of the parallel search over all entries.
	typedef struct packed {
		logic hit;
		idx_t hit_idx;
		idx_t oldest_idx;
		idx_t free_idx;
		logic full;
	} lkp_t;

endpackage

// ===== sv/lru_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Signals                                  Transfer when
// request   in         start, busy, command, key, value         start && !busy
// result    out        done, hit, read_value, evicted,          done
//                      evicted_key
// config    in         cfg_we, cfg_wdata                        cfg_we
//
// A request is registered on the edge that accepts it, searched and applied
// against all entries in the following cycle, and its result is registered
// and shown with done in the cycle after that; one request per cycle is
// sustained. The key compare and the rank update run over all entries at
// once, so busy never rises. The result receiver cannot stall; each result
// is valid for exactly one cycle. Reset clears all valid bits, ranks and the
// occupancy at once and restores the full capacity.
//
module lru_key_value_cache (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     command,
	input  lkv_pkg::key_t            key,
	input  lkv_pkg::value_t          value,
	output logic                     done,
	output logic                     hit,
	output lkv_pkg::value_t          read_value,
	output logic                     evicted,
	output lkv_pkg::key_t            evicted_key,
	input  logic                     cfg_we,
	input  lkv_pkg::cfg_t            cfg_wdata
);

	logic          valid_s1;
	lkv_pkg::req_t req_s1;
	lkv_pkg::rsp_t rsp;
	lkv_pkg::rsp_t rsp_s2;
	logic          valid_s2;
	lkv_pkg::cfg_t capacity_q;

	// Every request completes in one pass, so the block is always ready.
	assign busy = 1'b0;

	// Capacity register; the user must write it only while no request is in flight, the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lkv_pkg::cfg_t'(lkv_pkg::CAPACITY);
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	// Input register stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1.cmd   <= lkv_pkg::cmd_t'(command);
			req_s1.key   <= key;
			req_s1.value <= value;
		end
	end

	// The store updates its entries on the same edge that captures the result,
	// so a request that follows directly sees the updated contents.
	lkv_store u_store (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (valid_s1),
		.req          (req_s1),
		.capacity_cfg (capacity_q),
		.rsp          (rsp)
	);

	// Result register stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_s2 <= rsp;
		end
	end

	assign done        = valid_s2;
	assign hit         = rsp_s2.hit;
	assign read_value  = rsp_s2.read_value;
	assign evicted     = rsp_s2.evicted;
	assign evicted_key = rsp_s2.evicted_key;

endmodule

// ===== sv/lkv_lookup.sv =====
// ----------------------------------------------------------------------------
// lkv_lookup
// Parallel key match, oldest-entry search and free-slot search.
// ----------------------------------------------------------------------------
module lkv_lookup (
	input  lkv_pkg::key_t  key,
	input  logic [lkv_pkg::CAPACITY-1:0] entry_valid,
	input  lkv_pkg::key_t  entry_key [lkv_pkg::CAPACITY],
	input  lkv_pkg::rank_t entry_rank [lkv_pkg::CAPACITY],
	input  lkv_pkg::cnt_t  occupied,
	input  lkv_pkg::cfg_t  capacity_cfg,
	output lkv_pkg::lkp_t  lkp
);

	logic [lkv_pkg::CMP_BITS-1:0] cap_ext;
	logic [lkv_pkg::CMP_BITS-1:0] eff_cap;
	lkv_pkg::cnt_t                oldest_rank;

	// A setting of zero acts as one; a setting above the entry count saturates.
	always_comb begin
		cap_ext = lkv_pkg::CMP_BITS'(capacity_cfg);
		if (cap_ext == '0) begin
			eff_cap = lkv_pkg::CMP_BITS'(1);
		end else if (cap_ext > lkv_pkg::CMP_BITS'(lkv_pkg::CAPACITY)) begin
			eff_cap = lkv_pkg::CMP_BITS'(lkv_pkg::CAPACITY);
		end else begin
			eff_cap = cap_ext;
		end
	end

	// Valid ranks are distinct and dense, so the oldest entry holds occupied - 1.
	assign oldest_rank = occupied - lkv_pkg::cnt_t'(1);

	always_comb begin
		lkp.hit        = 1'b0;
		lkp.hit_idx    = '0;
		lkp.oldest_idx = '0;
		lkp.free_idx   = '0;
		lkp.full       = (lkv_pkg::CMP_BITS'(occupied) >= eff_cap);
		for (int i = 0; i < lkv_pkg::CAPACITY; i++) begin
			if (entry_valid[i] && (entry_key[i] == key)) begin
				lkp.hit     = 1'b1;
				lkp.hit_idx = lkv_pkg::idx_t'(i);
			end
			if (entry_valid[i] && (lkv_pkg::cnt_t'(entry_rank[i]) == oldest_rank)) begin
				lkp.oldest_idx = lkv_pkg::idx_t'(i);
			end
		end
		for (int i = lkv_pkg::CAPACITY - 1; i >= 0; i--) begin
			if (!entry_valid[i]) begin
				lkp.free_idx = lkv_pkg::idx_t'(i);
			end
		end
	end

endmodule

// ===== sv/lkv_store.sv =====
// ----------------------------------------------------------------------------
// lkv_store
// Entry registers with age ranks; serves and applies one request per cycle.
// ----------------------------------------------------------------------------
module lkv_store (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  lkv_pkg::req_t  req,
	input  lkv_pkg::cfg_t  capacity_cfg,
	output lkv_pkg::rsp_t  rsp
);

	lkv_pkg::key_t   key_q   [lkv_pkg::CAPACITY];
	lkv_pkg::value_t value_q [lkv_pkg::CAPACITY];
	lkv_pkg::rank_t  rank_q  [lkv_pkg::CAPACITY];
	logic [lkv_pkg::CAPACITY-1:0] valid_q;
	lkv_pkg::cnt_t   occ_q;

	lkv_pkg::lkp_t   lkp;
	lkv_pkg::idx_t   slot;
	lkv_pkg::rank_t  hit_rank;
	logic            is_set;
	logic            do_insert;

	lkv_lookup u_lookup (
		.key          (req.key),
		.entry_valid  (valid_q),
		.entry_key    (key_q),
		.entry_rank   (rank_q),
		.occupied     (occ_q),
		.capacity_cfg (capacity_cfg),
		.lkp          (lkp)
	);

	assign is_set    = (req.cmd == lkv_pkg::CMD_SET);
	assign do_insert = req_valid && is_set && !lkp.hit;
	// A new key goes into the evicted entry when full, else the lowest free one.
	assign slot      = lkp.full ? lkp.oldest_idx : lkp.free_idx;
	assign hit_rank  = rank_q[lkp.hit_idx];

	always_comb begin
		rsp.hit         = lkp.hit;
		rsp.read_value  = (lkp.hit && !is_set) ? value_q[lkp.hit_idx] : '0;
		rsp.evicted     = is_set && !lkp.hit && lkp.full;
		rsp.evicted_key = (is_set && !lkp.hit && lkp.full) ? key_q[lkp.oldest_idx] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			for (int i = 0; i < lkv_pkg::CAPACITY; i++) begin
				rank_q[i] <= '0;
			end
		end else if (req_valid) begin
			if (lkp.hit) begin
				for (int i = 0; i < lkv_pkg::CAPACITY; i++) begin
					if (valid_q[i] && (rank_q[i] < hit_rank)) begin
						rank_q[i] <= rank_q[i] + lkv_pkg::rank_t'(1);
					end
				end
				rank_q[lkp.hit_idx] <= '0;
			end else if (is_set) begin
				for (int i = 0; i < lkv_pkg::CAPACITY; i++) begin
					if (valid_q[i] && (lkv_pkg::idx_t'(i) != slot)) begin
						rank_q[i] <= rank_q[i] + lkv_pkg::rank_t'(1);
					end
				end
				rank_q[slot]  <= '0;
				valid_q[slot] <= 1'b1;
				if (!lkp.full) begin
					occ_q <= occ_q + lkv_pkg::cnt_t'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_insert) begin
			key_q[slot]   <= req.key;
			value_q[slot] <= req.value;
		end else if (req_valid && is_set && lkp.hit) begin
			value_q[lkp.hit_idx] <= req.value;
		end
	end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LRU key-value cache. A directed table and then
// random get/set traffic are sent under changing capacity settings. Results
// are compared field by field with a cycle-free cache model or hand-typed result.
// ----------------------------------------------------------------------------
module tb;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 8;
	localparam int PHASE_ITEMS   = 118;
	localparam int POOL_MAX      = 20;
	localparam int SETTLE_CYCLES = 8;
	localparam int REPORT_LIMIT  = 10;
	// The slowest legal run is about 1200 transfers with random gaps between them,
	// plus a drain before each capacity write. This limit is many times that.
	localparam int CYCLE_LIMIT   = 200000;

	// Rows of the directed table are either a request transfer or a capacity write.
	typedef enum logic {
		ROW_REQ = 1'b0,
		ROW_CFG = 1'b1
	} row_kind_t;

	// For a capacity row the setting is carried in the low bits of value.
	// When pinned is set, rsp is the result typed in by hand for that row.
	typedef struct packed {
		row_kind_t       kind;
		lkv_pkg::cmd_t   cmd;
		lkv_pkg::key_t   key;
		lkv_pkg::value_t value;
		logic            pinned;
		lkv_pkg::rsp_t   rsp;
	} stim_row_t;

	localparam int N_DIRECTED = 24;

	// The opening rows hit the key and value extremes on an empty cache. The
	// capacity is then dropped below the occupancy, forced to zero (which acts
	// as one), saturated with 31, set to two and finally restored to full.
	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		'{ROW_REQ, lkv_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1,
			'{1'b0, 32'h0000_0000, 1'b0, 32'h0000_0000}},
		'{ROW_REQ, lkv_pkg::CMD_SET, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
			'{1'b0, 32'h0000_0000, 1'b0, 32'h0000_0000}},
		'{ROW_REQ, lkv_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1,
			'{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000}},
		'{ROW_REQ, lkv_pkg::CMD_SET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
			'{1'b0, 32'h0000_0000, 1'b0, 32'h0000_0000}},
		'{ROW_REQ, lkv_pkg::CMD_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
			'{1'b1, 32'h0000_0000, 1'b0, 32'h0000_0000}},
		'{ROW_REQ, lkv_pkg::CMD_SET, 32'h0000_0000, 32'h0000_1234, 1'b1,
			'{1'b1, 32'h0000_0000, 1'b0, 32'h0000_0000}},
		'{ROW_REQ, lkv_pkg::CMD_GET, 32'h5555_5555, 32'h0000_0000, 1'b1,
			'{1'b0, 32'h0000_0000, 1'b0, 32'h0000_0000}},
		'{ROW_CFG, lkv_pkg::CMD_GET, 32'h0000_0000, 32'd1, 1'b0, '0},
		'{ROW_REQ, lkv_pkg::CMD_SET, 32'hAAAA_AAAA, 32'h5555_AAAA, 1'b1,
			'{1'b0, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF}},
		'{ROW_REQ, lkv_pkg::CMD_SET, 32'h0000_0001, 32'h0000_0001, 1'b1,
			'{1'b0, 32'h0000_0000, 1'b1, 32'h0000_0000}},
		'{ROW_CFG, lkv_pkg::CMD_GET, 32'h0000_0000, 32'd0, 1'b0, '0},
		'{ROW_REQ, lkv_pkg::CMD_GET, 32'hAAAA_AAAA, 32'h0000_0000, 1'b0, '0},
		'{ROW_REQ, lkv_pkg::CMD_SET, 32'h0000_0002, 32'hDEAD_0002, 1'b0, '0},
		'{ROW_REQ, lkv_pkg::CMD_SET, 32'h0000_0002, 32'h0BAD_0002, 1'b0, '0},
		'{ROW_CFG, lkv_pkg::CMD_GET, 32'h0000_0000, 32'd31, 1'b0, '0},
		'{ROW_REQ, lkv_pkg::CMD_SET, 32'h0000_0100, 32'h8000_0100, 1'b0, '0},
		'{ROW_REQ, lkv_pkg::CMD_SET, 32'h0000_0101, 32'h7FFF_0101, 1'b0, '0},
		'{ROW_REQ, lkv_pkg::CMD_GET, 32'hAAAA_AAAA, 32'h0000_0000, 1'b0, '0},
		'{ROW_REQ, lkv_pkg::CMD_GET, 32'h0000_0002, 32'h0000_0000, 1'b0, '0},
		'{ROW_CFG, lkv_pkg::CMD_GET, 32'h0000_0000, 32'd2, 1'b0, '0},
		'{ROW_REQ, lkv_pkg::CMD_SET, 32'h0000_0102, 32'h1234_5678, 1'b0, '0},
		'{ROW_REQ, lkv_pkg::CMD_GET, 32'h0000_0100, 32'h0000_0000, 1'b0, '0},
		'{ROW_CFG, lkv_pkg::CMD_GET, 32'h0000_0000, 32'd16, 1'b0, '0},
		'{ROW_REQ, lkv_pkg::CMD_GET, 32'h0000_0101, 32'h0000_0000, 1'b0, '0}
	};

	// One capacity setting per random phase. Extremes, out-of-range and low
	// values after a full cache are all in the list.
	localparam int N_PHASES = 10;
	localparam lkv_pkg::cfg_t PHASE_CAPACITY [N_PHASES] = '{
		5'd16, 5'd1, 5'd2, 5'd0, 5'd31, 5'd5, 5'd16, 5'd3, 5'd8, 5'd16
	};
	// The sender never pauses during this phase, so back-to-back transfers
	// run for a long stretch.
	localparam int QUIET_PHASE = 6;

	logic            clk       = 1'b0;
	logic            arst_n    = 1'b0;
	logic            start     = 1'b0;
	logic            busy;
	logic            command   = 1'b0;
	lkv_pkg::key_t   key       = '0;
	lkv_pkg::value_t value     = '0;
	logic            done;
	logic            hit;
	lkv_pkg::value_t read_value;
	logic            evicted;
	lkv_pkg::key_t   evicted_key;
	logic            cfg_we    = 1'b0;
	lkv_pkg::cfg_t   cfg_wdata = '0;

	// Hand-typed result that travels with the request driven alongside it.
	logic            pin_valid = 1'b0;
	lkv_pkg::rsp_t   pin_rsp   = '0;

	// Shadow copy of the cache contents and the capacity setting.
	lkv_pkg::key_t   cache_keys   [lkv_pkg::CAPACITY];
	lkv_pkg::value_t cache_values [lkv_pkg::CAPACITY];
	bit              cache_valid  [lkv_pkg::CAPACITY] = '{default: 1'b0};
	int unsigned     cache_rank   [lkv_pkg::CAPACITY] = '{default: 0};
	int unsigned     cache_count  = 0;
	lkv_pkg::cfg_t   capacity_reg = lkv_pkg::cfg_t'(lkv_pkg::CAPACITY);

	lkv_pkg::rsp_t   pending_results [$];
	int unsigned     mismatch_count = 0;
	int unsigned     cycle_count    = 0;

	lru_key_value_cache dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.key         (key),
		.value       (value),
		.done        (done),
		.hit         (hit),
		.read_value  (read_value),
		.evicted     (evicted),
		.evicted_key (evicted_key),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Applies one request to the shadow cache and returns the result it must
	// produce. Rank 0 is the most recent entry; larger ranks are older.
	function automatic lkv_pkg::rsp_t apply_cache_request(lkv_pkg::cmd_t cmd_in,
			lkv_pkg::key_t key_in, lkv_pkg::value_t value_in);
		lkv_pkg::rsp_t r;
		int            found;
		int            victim;
		int            slot;
		int unsigned   limit;
		int unsigned   age;
		r      = '0;
		found  = -1;
		victim = -1;
		slot   = -1;
		// A setting of zero behaves as one, and anything above the size saturates.
		if (capacity_reg == 0)
			limit = 1;
		else if (capacity_reg > lkv_pkg::CAPACITY)
			limit = lkv_pkg::CAPACITY;
		else
			limit = 32'(capacity_reg);
		for (int i = 0; i < lkv_pkg::CAPACITY; i++)
			if (cache_valid[i] && cache_keys[i] == key_in)
				found = i;
		if (found >= 0) begin
			// A hit on either command refreshes the entry; only a set rewrites it.
			r.hit = 1'b1;
			if (cmd_in == lkv_pkg::CMD_SET)
				cache_values[found] = value_in;
			else
				r.read_value = cache_values[found];
			age = cache_rank[found];
			for (int i = 0; i < lkv_pkg::CAPACITY; i++)
				if (cache_valid[i] && cache_rank[i] < age)
					cache_rank[i]++;
			cache_rank[found] = 0;
		end else if (cmd_in == lkv_pkg::CMD_SET) begin
			if (cache_count >= limit) begin
				// Evict the oldest entry and reuse its slot. When the capacity was
				// lowered below the occupancy, only one entry goes per insert.
				for (int i = 0; i < lkv_pkg::CAPACITY; i++)
					if (cache_valid[i] && (victim < 0 || cache_rank[i] > cache_rank[victim]))
						victim = i;
				r.evicted           = 1'b1;
				r.evicted_key       = cache_keys[victim];
				cache_valid[victim] = 1'b0;
				cache_count--;
				slot = victim;
			end else begin
				for (int i = lkv_pkg::CAPACITY - 1; i >= 0; i--)
					if (!cache_valid[i])
						slot = i;
			end
			for (int i = 0; i < lkv_pkg::CAPACITY; i++)
				if (cache_valid[i])
					cache_rank[i]++;
			cache_keys[slot]   = key_in;
			cache_values[slot] = value_in;
			cache_valid[slot]  = 1'b1;
			cache_rank[slot]   = 0;
			cache_count++;
		end
		return r;
	endfunction

	task automatic log_mismatch(string why, lkv_pkg::rsp_t want, lkv_pkg::rsp_t got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT) begin
			$display("tb: %s at cycle %0d:", why, cycle_count);
			$display("  expected hit=%0b rd=%h ev=%0b evk=%h",
				want.hit, want.read_value, want.evicted, want.evicted_key);
			$display("  got      hit=%0b rd=%h ev=%0b evk=%h",
				got.hit, got.read_value, got.evicted, got.evicted_key);
		end
	endtask

	// Everything is sampled at the rising edge, before the block's registers
	// update, so every value read here belongs to the cycle that just ended.
	// A correct block shows a result only after its transfer has passed the input
	// and result registers, so checking before recording the new transfer is safe.
	always @(posedge clk) begin
		lkv_pkg::rsp_t seen;
		lkv_pkg::rsp_t want;
		lkv_pkg::rsp_t model_out;
		if (arst_n && done) begin
			seen = '{hit, read_value, evicted, evicted_key};
			if (pending_results.size() == 0) begin
				log_mismatch("result with none outstanding", '0, seen);
			end else begin
				want = pending_results.pop_front();
				if (seen.hit !== want.hit || seen.read_value !== want.read_value ||
						seen.evicted !== want.evicted || seen.evicted_key !== want.evicted_key)
					log_mismatch("result mismatch", want, seen);
			end
		end
		if (arst_n && cfg_we)
			capacity_reg = cfg_wdata;
		if (arst_n && start && !busy) begin
			// The shadow cache always advances; a pinned row overrides its output.
			model_out = apply_cache_request(lkv_pkg::cmd_t'(command), key, value);
			pending_results.push_back(pin_valid ? pin_rsp : model_out);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Presents one request and returns at the edge where it is transferred.
	// Start stays high into the next request unless a gap is inserted, so it
	// never gets two assignments in one time step.
	task automatic send_request(lkv_pkg::cmd_t c, lkv_pkg::key_t k, lkv_pkg::value_t v,
			logic pinned, lkv_pkg::rsp_t r, bit allow_gap);
		if (allow_gap && $urandom_range(99) < 30) begin
			start <= 1'b0;
			repeat ($urandom_range(2, 1)) @(posedge clk);
		end
		start     <= 1'b1;
		command   <= c;
		key       <= k;
		value     <= v;
		pin_valid <= pinned;
		pin_rsp   <= r;
		do
			@(posedge clk);
		while (busy);
	endtask

	// The capacity is only changed with the cache idle: all outstanding results
	// must have come back, and the pipeline is then left to settle before the write.
	task automatic write_capacity(lkv_pkg::cfg_t setting);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= setting;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		lkv_pkg::key_t key_pool [POOL_MAX];
		int unsigned   pool_size;
		lkv_pkg::key_t pick;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[n]) begin
			if (DIRECTED[n].kind == ROW_CFG)
				write_capacity(lkv_pkg::cfg_t'(DIRECTED[n].value));
			else
				send_request(DIRECTED[n].cmd, DIRECTED[n].key, DIRECTED[n].value,
					DIRECTED[n].pinned, DIRECTED[n].rsp, 1'b1);
		end

		// Random phases. Most keys come from a small per-phase pool so that gets
		// hit, sets update and inserts evict; the rest are fresh random keys.
		// Pool keys are full-width random values, so every key bit toggles.
		foreach (PHASE_CAPACITY[p]) begin
			write_capacity(PHASE_CAPACITY[p]);
			pool_size = $urandom_range(POOL_MAX, 1);
			for (int j = 0; j < POOL_MAX; j++)
				key_pool[j] = $urandom();
			for (int j = 0; j < PHASE_ITEMS; j++) begin
				if ($urandom_range(99) < 90)
					pick = key_pool[$urandom_range(pool_size - 1)];
				else
					pick = $urandom();
				send_request(lkv_pkg::cmd_t'($urandom_range(1)), pick, $urandom(), 1'b0, '0,
					p != QUIET_PHASE);
			end
		end

		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// Extra cycles catch any stray result that arrives late.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== lru_key_value_cache.f =====
sv/lkv_pkg.sv
sv/lkv_lookup.sv
sv/lkv_store.sv
sv/lru_key_value_cache.sv
bench/tb.sv
